// ----- rtl/bank_controller_with_clock_latch_core_macros.svh -----
// Assertion macros for the bank controller core.
// Included by the top level; relies on clk and rst being in scope.
`ifndef BANK_CONTROLLER_WITH_CLOCK_LATCH_CORE_MACROS_SVH
`define BANK_CONTROLLER_WITH_CLOCK_LATCH_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define BCL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define BCL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bcl_pkg.sv -----
// Package for the bank controller core: transaction types, address windows,
// register indexes and sizing defaults. No dependencies.
package bcl_pkg;

  // Sizing defaults for the top-level parameters
  localparam int RAM_BANKS_DEF      = 4;
  localparam int RAM_BANK_BYTES_DEF = 8192;
  localparam int ROM_BANK_BITS_DEF  = 7;

  // Bank select register width and clock register count
  localparam int ROM_SEL_W   = 7;
  localparam int CLK_REGS    = 5;
  localparam int CLK_IDX_W   = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 1;

  // Access kinds
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_RAM   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_CLOCK = 1'b1;

  // Bus address windows
  localparam logic [15:0] WIN_ENABLE_END  = 16'h1FFF;
  localparam logic [15:0] WIN_ROMBANK_END = 16'h3FFF;
  localparam logic [15:0] WIN_SELECT_END  = 16'h5FFF;
  localparam logic [15:0] WIN_LATCH_END   = 16'h7FFF;
  localparam logic [15:0] ROM_WIN_LO      = 16'h4000;
  localparam logic [15:0] EXT_WIN_LO      = 16'hA000;
  localparam logic [15:0] EXT_WIN_HI      = 16'hBFFF;

  // Data codes
  localparam logic [3:0] ENABLE_CODE = 4'hA;
  localparam logic [7:0] LATCH_ARM   = 8'h00;
  localparam logic [7:0] LATCH_FIRE  = 8'h01;
  localparam logic [7:0] CLK_SEL_LO  = 8'h08;
  localparam logic [7:0] CLK_SEL_HI  = 8'h0C;
  localparam logic [5:0] SEC_MAX     = 6'd59;

  typedef struct packed {
    logic        kind;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [5:0]  now_seconds;
    logic [5:0]  now_minutes;
    logic [4:0]  now_hours;
    logic [8:0]  now_day;
  } bus_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        rom_access;
    logic [20:0] rom_address;
  } result_item_t;

endpackage

// ----- rtl/bank_controller_with_clock_latch_core.sv -----
// Top level of the bank controller core: control registers, clock registers,
// banked RAM and the result register. Depends on bcl_pkg and the macro header.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------
//  bus      | bus_valid, bus_stall | bus_item (bus_item_t)
//  result   | res_valid, res_stall | res_item (result_item_t)
//  cfg      | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// One transaction is taken per cycle while bus_stall is low; its result appears
// in the next cycle, with RAM data from the registered read port of the banked RAM.
// bus_stall follows a stalled result register: a new transaction is taken
// whenever the result register is empty or is being taken in that cycle.
// Reset clears control and clock registers; the RAM is not cleared and has
// no clearing pass. cfg_ready is always high.
`include "bank_controller_with_clock_latch_core_macros.svh"

module bank_controller_with_clock_latch_core
  import bcl_pkg::*;
#(
  parameter int RAM_BANKS      = RAM_BANKS_DEF,
  parameter int RAM_BANK_BYTES = RAM_BANK_BYTES_DEF,
  parameter int ROM_BANK_BITS  = ROM_BANK_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  bus_valid,
  output logic                  bus_stall,
  input  bus_item_t             bus_item,
  output logic                  res_valid,
  input  logic                  res_stall,
  output result_item_t          res_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int RAM_DEPTH = RAM_BANKS * RAM_BANK_BYTES;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam logic [15:0] BANK_B1 = 16'(RAM_BANK_BYTES);
  localparam logic [15:0] BANK_B2 = 16'(2 * RAM_BANK_BYTES);
  localparam logic [15:0] BANK_B4 = 16'(4 * RAM_BANK_BYTES);
  localparam logic [ROM_SEL_W-1:0] ROM_MASK = ROM_SEL_W'((1 << ROM_BANK_BITS) - 1);

  // Configuration and control state
  logic                 has_ram, has_clock;
  logic                 ram_enable, clock_enable, latch_armed;
  logic [ROM_SEL_W-1:0] rom_bank_sel;
  logic [7:0]           ram_or_clock_sel;
  logic [7:0]           clock_regs [CLK_REGS];

  // Banked RAM
  logic [7:0]        ram_mem [RAM_DEPTH];
  logic [7:0]        ram_q;
  logic [RAM_AW-1:0] ram_idx;
  logic              ram_we, ram_re;

  // Result register
  logic        res_use_ram;
  logic [7:0]  res_byte;
  logic        res_rom_access;
  logic [20:0] res_rom_address;

  // Decode
  logic                 accept;
  logic                 is_write;
  logic                 win_enable, win_rombank, win_select, win_latch, win_rom, win_ext;
  logic                 tgt_ram, tgt_clk;
  logic [CLK_IDX_W-1:0] clk_idx;
  logic [15:0]          off_r0, off_r1, off_r2, off_r3;
  logic [ROM_SEL_W-1:0] bank_eff;
  logic [5:0]           sec_sat;

  assign cfg_ready = 1'b1;
  assign bus_stall = res_valid & res_stall;
  assign accept    = bus_valid & ~bus_stall;
  assign is_write  = (bus_item.kind == KIND_WRITE);

  // Address windows
  assign win_enable  = bus_item.address <= WIN_ENABLE_END;
  assign win_rombank = ~win_enable && (bus_item.address <= WIN_ROMBANK_END);
  assign win_select  = (bus_item.address > WIN_ROMBANK_END) &&
                       (bus_item.address <= WIN_SELECT_END);
  assign win_latch   = (bus_item.address > WIN_SELECT_END) &&
                       (bus_item.address <= WIN_LATCH_END);
  assign win_rom     = (bus_item.address >= ROM_WIN_LO) &&
                       (bus_item.address <= WIN_LATCH_END);
  assign win_ext     = (bus_item.address >= EXT_WIN_LO) &&
                       (bus_item.address <= EXT_WIN_HI);

  // External window target: RAM first, then clock register
  assign tgt_ram = ram_enable && (32'(ram_or_clock_sel) < 32'(RAM_BANKS));
  assign tgt_clk = ~tgt_ram && clock_enable &&
                   (ram_or_clock_sel >= CLK_SEL_LO) && (ram_or_clock_sel <= CLK_SEL_HI);
  assign clk_idx = CLK_IDX_W'(ram_or_clock_sel - CLK_SEL_LO);

  // Wrap the window offset into one bank (quotient is at most seven)
  always_comb begin
    off_r0 = {3'b000, bus_item.address[12:0]};
    off_r1 = (off_r0 >= BANK_B4) ? off_r0 - BANK_B4 : off_r0;
    off_r2 = (off_r1 >= BANK_B2) ? off_r1 - BANK_B2 : off_r1;
    off_r3 = (off_r2 >= BANK_B1) ? off_r2 - BANK_B1 : off_r2;
    ram_idx = RAM_AW'(32'(ram_or_clock_sel) * 32'(RAM_BANK_BYTES) + 32'(off_r3));
  end

  assign ram_we = accept && is_write && win_ext && tgt_ram;
  assign ram_re = accept && !is_write && win_ext && tgt_ram;

  assign bank_eff = (rom_bank_sel == '0) ? ROM_SEL_W'(1) : rom_bank_sel;
  assign sec_sat  = (bus_item.now_seconds > SEC_MAX) ? SEC_MAX : bus_item.now_seconds;

  // Write and read the banked RAM
  always_ff @(posedge clk) begin
    if (ram_we) begin
      ram_mem[ram_idx] <= bus_item.write_data;
    end
    if (ram_re) begin
      ram_q <= ram_mem[ram_idx];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      has_ram   <= 1'b1;
      has_clock <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HAS_RAM:   has_ram   <= cfg_data[0];
        CFG_HAS_CLOCK: has_clock <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Control registers: apply write transactions in address order
  always_ff @(posedge clk) begin
    if (rst) begin
      ram_enable       <= 1'b0;
      clock_enable     <= 1'b0;
      latch_armed      <= 1'b0;
      rom_bank_sel     <= '0;
      ram_or_clock_sel <= '0;
      for (int i = 0; i < CLK_REGS; i++) begin
        clock_regs[i] <= '0;
      end
    end else if (accept && is_write) begin
      priority if (win_enable) begin
        if (bus_item.write_data[3:0] == ENABLE_CODE) begin
          if (has_ram)   ram_enable   <= 1'b1;
          if (has_clock) clock_enable <= 1'b1;
        end else begin
          ram_enable   <= 1'b0;
          clock_enable <= 1'b0;
        end
      end else if (win_rombank) begin
        rom_bank_sel <= bus_item.write_data[ROM_SEL_W-1:0] & ROM_MASK;
      end else if (win_select) begin
        ram_or_clock_sel <= bus_item.write_data;
      end else if (win_latch) begin
        if (clock_enable) begin
          priority if (bus_item.write_data == LATCH_ARM) begin
            latch_armed <= 1'b1;
          end else if (bus_item.write_data == LATCH_FIRE && latch_armed) begin
            // Capture the current time and disarm
            latch_armed   <= 1'b0;
            clock_regs[0] <= {2'b00, sec_sat};
            clock_regs[1] <= {2'b00, bus_item.now_minutes};
            clock_regs[2] <= {3'b000, bus_item.now_hours};
            clock_regs[3] <= bus_item.now_day[7:0];
            clock_regs[4] <= {clock_regs[4][7:1], bus_item.now_day[8]};
          end else begin
            latch_armed <= 1'b0;
          end
        end
      end else if (win_ext && tgt_clk) begin
        clock_regs[clk_idx] <= bus_item.write_data;
      end else begin
        // other addresses: drop the write
      end
    end
  end

  // Result register: advance on accept, drop once taken, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_use_ram     <= ram_re;
      res_rom_access  <= !is_write && win_rom;
      res_rom_address <= (!is_write && win_rom) ? {bank_eff, bus_item.address[13:0]} : '0;
      res_byte        <= (!is_write && win_ext && tgt_clk) ? clock_regs[clk_idx] : '0;
    end
  end

  always_comb begin
    res_item.read_data   = res_use_ram ? ram_q : res_byte;
    res_item.rom_access  = res_rom_access;
    res_item.rom_address = res_rom_address;
  end

  // Checks
  `BCL_ASSERT_NEXT(a_result_follows, bus_valid && !bus_stall, res_valid, "accepted transaction gave no result")
  `BCL_ASSERT_NOW(a_rom_no_data, res_valid && res_item.rom_access, res_item.read_data == 8'h00, "ROM read carries data byte")
  `BCL_ASSERT_NOW(a_rom_bank_nonzero, res_valid && res_item.rom_access, res_item.rom_address[20:14] != 7'd0, "ROM read mapped to bank zero")

endmodule
